### src/tos_pkg.sv
// Package: shared types and constants for the tile occupancy set.
package tos_pkg;

  localparam int Capacity  = 64;
  localparam int CoordBits = 16;
  localparam int FracBits  = 16;
  localparam int One       = 1 << FracBits;
  localparam int CntBits   = $clog2(Capacity + 1);
  localparam int IdxBits   = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int BndBits   = 36;

  typedef logic [CoordBits-1:0] coord_t;
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } tile_t;

  typedef enum logic [2:0] {
    CMD_ADD      = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_CONTAINS = 3'd2,
    CMD_CLEAR    = 3'd3,
    CMD_BUILD    = 3'd4
  } cmd_e;

  localparam logic [1:0] REG_INV_X = 2'd0;
  localparam logic [1:0] REG_INV_Y = 2'd1;
  localparam logic [1:0] REG_INV_Z = 2'd2;
  localparam logic [1:0] REG_THR   = 2'd3;

  // Control broadcast from the controller to every cell.
  typedef struct packed {
    logic  clear;
    logic  push;
    logic  shift;
    tile_t data;
    tile_t key;
  } cell_ctl_t;

endpackage

### src/tos_cell.sv
// One cell of the tile chain: holds one entry, compares it, shifts toward the head.
module tos_cell
  import tos_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  logic      tail_i,     // this cell is the first empty slot
  input  logic      prev_hit_i, // a cell closer to the head matched
  input  logic      next_vld_i,
  input  tile_t     next_i,
  output logic      vld_o,
  output logic      hit_o,
  output tile_t     data_o
);
  logic  vld_q, vld_d;
  tile_t data_q, data_d;
  logic  match;
  logic  take;

  assign match = vld_q && (data_q == ctl_i.key);
  assign hit_o = prev_hit_i || match;
  // remove: cells at or after first match take neighbor's entry
  assign take  = ctl_i.shift && hit_o;

  always_comb begin
    vld_d  = vld_q;
    data_d = data_q;
    if (ctl_i.clear) begin
      vld_d = 1'b0;
    end else if (take) begin
      vld_d  = next_vld_i;
      data_d = next_i;
    end else if (ctl_i.push && tail_i) begin
      vld_d  = 1'b1;
      data_d = ctl_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;
endmodule

### src/tos_scale.sv
// Bound scaler: Q18.16 signed times unsigned Q16.16, then rounding to a tile bound.
module tos_scale
  import tos_pkg::*;
(
  input  logic                      clk_i,
  input  logic signed [33:0]        a_i,
  input  logic [31:0]               s_i,
  input  logic                      post_i,  // add one tile after the product
  input  logic                      half_i,
  input  logic                      up_i,
  input  logic [15:0]               thr_i,
  output logic signed [BndBits-1:0] b_o
);
  logic        neg;
  logic [31:0] mag;
  logic [63:0] prod;
  logic [47:0] r_q;
  logic        neg_q, post_q, half_q, up_q;
  logic signed [51:0] rs, v;
  logic signed [51:0] v_q;
  logic        half2_q, up2_q;
  logic [51:0] vabs, vm;
  logic [51:0] vm_q;
  logic        vneg_q, up3_q;
  logic [FracBits-1:0] fr;
  logic signed [BndBits-1:0] t;
  logic signed [BndBits-1:0] b_q;

  assign neg  = a_i[33];
  // |a| stays below 2^32 for every bound
  assign mag  = neg ? 32'(-a_i) : 32'(a_i);
  assign prod = {32'd0, mag} * {32'd0, s_i};

  always_ff @(posedge clk_i) begin
    r_q    <= prod[63:FracBits];
    neg_q  <= neg;
    post_q <= post_i;
    half_q <= half_i;
    up_q   <= up_i;
  end

  assign rs = $signed({4'b0, r_q});
  assign v  = (neg_q ? -rs : rs) + (post_q ? 52'(One) : 52'sd0);

  always_ff @(posedge clk_i) begin
    v_q     <= v;
    half2_q <= half_q;
    up2_q   <= up_q;
  end

  assign vabs = v_q[51] ? 52'(-v_q) : 52'(v_q);
  assign vm   = half2_q ? (vabs >> 1) : vabs;

  always_ff @(posedge clk_i) begin
    vm_q   <= vm;
    vneg_q <= v_q[51];
    up3_q  <= up2_q;
  end

  assign fr = vm_q[FracBits-1:0];

  always_comb begin
    t = BndBits'(vm_q >> FracBits);
    if (vneg_q) t = -t;
    if (fr > thr_i) t = up3_q ? t + 1 : t - 1;
  end

  always_ff @(posedge clk_i) begin
    b_q <= t;
  end
  assign b_o = b_q;
endmodule

### src/tile_occupancy_set.sv
// Top level: tile occupancy set with a chain of storage cells and a build sequencer.
// One command is handled at a time: it is taken while idle and executes in ST_EXEC. The cell chain
// compares all entries at once and shifts in one step, so for add, remove, contains and clear the
// result is offered in the cycle after ST_EXEC. Build instead computes its bounds in ST_SCALE through
// one shared four-stage pipelined scaler, then in ST_ENUM stores one tile per cycle, with a step of its
// own for each row or layer change, capped by the 64-entry capacity. The result holds until taken.
module tile_occupancy_set
  import tos_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd[2:0], tile_x[18:3], tile_y[34:19], tile_z[50:35], box_min_x[82:51],
  // box_min_y[114:83], box_min_z[146:115], box_max_x[178:147],
  // box_max_y[210:179], box_max_z[242:211], zero pad to 248
  input  logic [247:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // found[0], accepted[1], overflow[2], entry_count[9:3], zero pad to 16
  output logic [15:0]  m_axis_tdata
);
  typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_SCALE, ST_ENUM, ST_DONE} state_e;

  state_e state_q;
  logic [31:0] inv_x_q, inv_y_q, inv_z_q;
  logic [15:0] thr_q;
  logic [247:0] in_q;
  logic [CntBits-1:0] cnt_q;
  logic found_q, acc_q, ovf_q;
  logic [3:0] step_q;
  logic signed [BndBits-1:0] px_q, mx_q, pw_q, mw_q, py_q, my_q, pz_q, mz_q;
  logic signed [BndBits-1:0] x_q, y_q, z_q;

  cell_ctl_t ctl;
  logic [Capacity:0] hit;
  logic [Capacity:0] vld;
  tile_t dat [Capacity+1];
  logic [2:0] cmd;
  tile_t key;

  assign cmd = in_q[2:0];
  assign key = '{z: in_q[50:35], y: in_q[34:19], x: in_q[18:3]};

  assign hit[0] = 1'b0;
  assign vld[Capacity] = 1'b0;
  assign dat[Capacity] = '0;

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    tos_cell u_cell (
      .clk_i, .rst_ni, .ctl_i(ctl),
      .tail_i(cnt_q == CntBits'(g)),
      .prev_hit_i(hit[g]),
      .next_vld_i(vld[g+1]), .next_i(dat[g+1]),
      .vld_o(vld[g]), .hit_o(hit[g+1]), .data_o(dat[g])
    );
  end

  // shared scaler
  logic signed [33:0] sc_a;
  logic [31:0] sc_s;
  logic sc_post, sc_half, sc_up;
  logic signed [BndBits-1:0] sc_b;

  always_comb begin
    sc_a = '0; sc_s = inv_x_q; sc_post = 1'b0; sc_half = 1'b0; sc_up = 1'b1;
    case (step_q)
      4'd0: begin sc_a = 34'($signed(in_q[178:147])); sc_post = 1'b1; sc_half = 1'b1; end
      4'd1: begin sc_a = 34'($signed(in_q[82:51])); sc_post = 1'b1; sc_half = 1'b1;
                  sc_up = 1'b0; end
      4'd2: begin sc_a = 34'($signed(in_q[178:147])); sc_half = 1'b1; end
      4'd3: begin sc_a = 34'($signed(in_q[82:51])); sc_half = 1'b1; sc_up = 1'b0; end
      4'd4: begin sc_a = 34'($signed(in_q[210:179])) + 34'(One / 2); sc_s = inv_y_q; end
      4'd5: begin sc_a = 34'($signed(in_q[114:83])) + 34'(One); sc_s = inv_y_q;
                  sc_up = 1'b0; end
      4'd6: begin sc_a = 34'($signed(in_q[242:211])); sc_s = inv_z_q; end
      4'd7: begin sc_a = 34'($signed(in_q[146:115])); sc_s = inv_z_q; sc_up = 1'b0; end
      default: ;
    endcase
  end

  // the first two x bounds add one tile after the product, then halve; the other two only halve
  tos_scale u_scale (
    .clk_i, .a_i(sc_a), .s_i(sc_s), .post_i(sc_post), .half_i(sc_half), .up_i(sc_up),
    .thr_i(thr_q), .b_o(sc_b)
  );

  logic odd;
  logic signed [BndBits-1:0] lo, hi;
  assign odd = y_q[0];
  assign lo  = odd ? mw_q : mx_q;
  assign hi  = odd ? pw_q : px_q;

  logic full;
  assign full = (cnt_q == CntBits'(Capacity));

  always_comb begin
    ctl = '0;
    ctl.key = key;
    ctl.data = key;
    if (state_q == ST_EXEC) begin
      case (cmd)
        CMD_ADD:    ctl.push  = !full;
        CMD_REMOVE: ctl.shift = 1'b1;
        CMD_CLEAR, CMD_BUILD: ctl.clear = 1'b1;
        default: ;
      endcase
    end else if (state_q == ST_ENUM && x_q < hi && !full) begin
      ctl.push = 1'b1;
      ctl.data = '{z: z_q[CoordBits-1:0], y: y_q[CoordBits-1:0], x: x_q[CoordBits-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_x_q <= 32'd65536; inv_y_q <= 32'd65536; inv_z_q <= 32'd65536;
      thr_q <= 16'd32768;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INV_X: inv_x_q <= cfg_data_i;
        REG_INV_Y: inv_y_q <= cfg_data_i;
        REG_INV_Z: inv_z_q <= cfg_data_i;
        REG_THR:   thr_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0; found_q <= 1'b0; acc_q <= 1'b0; ovf_q <= 1'b0; step_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: if (s_axis_tvalid) begin
          state_q <= ST_EXEC;
          found_q <= 1'b0; acc_q <= 1'b0; ovf_q <= 1'b0; step_q <= '0;
        end
        ST_EXEC: begin
          state_q <= ST_DONE;
          case (cmd)
            CMD_ADD: if (!full) begin acc_q <= 1'b1; cnt_q <= cnt_q + 1'b1; end
            CMD_REMOVE: if (hit[Capacity]) begin
              found_q <= 1'b1; cnt_q <= cnt_q - 1'b1;
            end
            CMD_CONTAINS: found_q <= hit[Capacity];
            CMD_CLEAR: cnt_q <= '0;
            CMD_BUILD: begin cnt_q <= '0; state_q <= ST_SCALE; end
            default: ;
          endcase
        end
        ST_SCALE: begin
          step_q <= step_q + 1'b1;
          case (step_q)
            4'd4:  px_q <= sc_b;
            4'd5:  mx_q <= sc_b;
            4'd6:  pw_q <= sc_b;
            4'd7:  mw_q <= sc_b;
            4'd8:  py_q <= sc_b;
            4'd9:  my_q <= sc_b;
            4'd10: pz_q <= sc_b;
            4'd11: mz_q <= sc_b;
            default: ;
          endcase
          if (step_q == 4'd12) begin
            // a single row whose x range is empty yields no tile on any layer
            if (pz_q <= mz_q || py_q <= my_q || (px_q <= mx_q && pw_q <= mw_q) ||
                (py_q == my_q + 1 && (my_q[0] ? pw_q <= mw_q : px_q <= mx_q))) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_ENUM;
              z_q <= pz_q; y_q <= my_q;
              x_q <= my_q[0] ? mw_q : mx_q;
            end
          end
        end
        ST_ENUM: begin
          if (x_q < hi) begin
            if (full) begin
              ovf_q <= 1'b1; state_q <= ST_DONE;
            end else begin
              cnt_q <= cnt_q + 1'b1; x_q <= x_q + 1;
            end
          end else if (y_q + 1 < py_q) begin
            y_q <= y_q + 1;
            x_q <= (y_q[0]) ? mx_q : mw_q;
          end else if (z_q - 1 > mz_q) begin
            z_q <= z_q - 1; y_q <= my_q;
            x_q <= my_q[0] ? mw_q : mx_q;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: if (m_axis_tready) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) in_q <= s_axis_tdata;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_DONE);
  assign m_axis_tdata  = {6'd0, cnt_q, ovf_q, acc_q, found_q};

`ifndef SYNTH
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(Capacity)) else $error("count above capacity");
  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0({found_q, acc_q, ovf_q})) else $error("flags");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("overlap");
`endif
endmodule

### verif/tb_tile_occupancy_set.sv
// Testbench for tile_occupancy_set: directed and random commands checked against a predictor.
`timescale 1ns / 1ps

module tb_tile_occupancy_set
  import tos_pkg::*;
();

  localparam int Depth = 64;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // cmd, tile_x, tile_y, tile_z, box_min_x/y/z, box_max_x/y/z, zero pad
  logic [247:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // found, accepted, overflow, entry_count, zero pad
  logic [15:0]  m_axis_tdata;

  tile_occupancy_set i_dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("tb_tile_occupancy_set failed");
    $finish;
  end

  // occupancy model
  logic [31:0] inv_x, inv_y, inv_z;
  logic [15:0] thr;
  tile_t       tiles [Depth];
  int          fill;
  logic [9:0]  expected_q [$];
  int          errors = 0;
  int          n_sent = 0, n_checked = 0, n_builds = 0, n_overflow = 0, n_full = 0;
  int          send_idle = 0, recv_idle = 0;
  bit          hold_recv = 0;

  function automatic longint scale(longint a, logic [31:0] s);
    longint unsigned mag;
    longint unsigned r;
    mag = (a < 0) ? -a : a;
    r = (mag * s) >> FracBits;
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint bnd(longint v, bit up);
    longint unsigned mag;
    longint unsigned fr;
    longint r;
    mag = (v < 0) ? -v : v;
    fr = mag & 64'hFFFF;
    r = longint'(mag >> FracBits);
    if (v < 0) r = -r;
    if (fr > thr) r += up ? 1 : -1;
    return r;
  endfunction

  function automatic bit store_tile(longint x, longint y, longint z);
    if (fill >= Depth) return 0;
    tiles[fill] = '{z: coord_t'(z), y: coord_t'(y), x: coord_t'(x)};
    fill++;
    return 1;
  endfunction

  function automatic int find_tile(tile_t t);
    for (int i = 0; i < fill; i++) if (tiles[i] == t) return i;
    return -1;
  endfunction

  function automatic bit build_tiles(logic [247:0] d);
    longint sxmax, sxmin, px, mx, pw, mw, py, my, pz, mz;
    bit odd;
    longint lo, hi;
    sxmax = scale(longint'($signed(d[178:147])), inv_x);
    sxmin = scale(longint'($signed(d[82:51])), inv_x);
    px = bnd((sxmax + 65536) / 2, 1);
    mx = bnd((sxmin + 65536) / 2, 0);
    pw = bnd(sxmax / 2, 1);
    mw = bnd(sxmin / 2, 0);
    py = bnd(scale(longint'($signed(d[210:179])) + 32768, inv_y), 1);
    my = bnd(scale(longint'($signed(d[114:83])) + 65536, inv_y), 0);
    pz = bnd(scale(longint'($signed(d[242:211])), inv_z), 1);
    mz = bnd(scale(longint'($signed(d[146:115])), inv_z), 0);
    fill = 0;
    if (pz <= mz || py <= my || (px <= mx && pw <= mw)) return 0;
    // one row with an empty x range gives no tile on any layer
    if (py == my + 1 && (my[0] ? pw <= mw : px <= mx)) return 0;
    for (longint z = pz; z > mz; z--)
      for (longint y = my; y < py; y++) begin
        odd = y[0];
        lo = odd ? mw : mx;
        hi = odd ? pw : px;
        for (longint x = lo; x < hi; x++)
          if (!store_tile(x, y, z)) return 1;
      end
    return 0;
  endfunction

  function automatic logic [9:0] predict_result(logic [247:0] d);
    tile_t t;
    bit found, acc, ovf;
    int idx;
    t = '{z: d[50:35], y: d[34:19], x: d[18:3]};
    found = 0; acc = 0; ovf = 0;
    case (d[2:0])
      CMD_ADD: begin
        acc = store_tile(t.x, t.y, t.z);
        if (!acc) n_full++;
      end
      CMD_REMOVE: begin
        idx = find_tile(t);
        if (idx >= 0) begin
          for (int i = idx; i + 1 < fill; i++) tiles[i] = tiles[i+1];
          fill--;
          found = 1;
        end
      end
      CMD_CONTAINS: found = find_tile(t) >= 0;
      CMD_CLEAR: fill = 0;
      CMD_BUILD: begin
        ovf = build_tiles(d);
        n_builds++;
        if (ovf) n_overflow++;
      end
      default: ;
    endcase
    return {7'(fill), ovf, acc, found};
  endfunction

  task automatic send_item(logic [247:0] d);
    logic [9:0] e;
    @(posedge clk_i);
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    e = predict_result(d);
    expected_q = {expected_q, e};
    n_sent++;
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    int guard = 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_INV_X: inv_x = val;
      REG_INV_Y: inv_y = val;
      REG_INV_Z: inv_z = val;
      default:   thr = val[15:0];
    endcase
  endtask

  function automatic logic [247:0] tile_cmd(cmd_e c, int x, int y, int z);
    logic [247:0] d;
    d = 248'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom});
    d[247:243] = '0;
    d[2:0] = c;
    d[18:3] = 16'(x); d[34:19] = 16'(y); d[50:35] = 16'(z);
    return d;
  endfunction

  function automatic logic [247:0] box_cmd(int mnx, int mny, int mnz, int mxx, int mxy,
                                           int mxz);
    logic [247:0] d;
    d = tile_cmd(CMD_BUILD, int'($urandom), int'($urandom), int'($urandom));
    d[82:51] = mnx; d[114:83] = mny; d[146:115] = mnz;
    d[178:147] = mxx; d[210:179] = mxy; d[242:211] = mxz;
    return d;
  endfunction

  // small tile values so lookups hit often
  function automatic int near_coord();
    return ($urandom_range(3) == 0) ? int'($urandom) : $signed($urandom_range(6)) - 3;
  endfunction

  function automatic int box_coord(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  task automatic random_item();
    int r;
    int a, b;
    logic [247:0] d;
    r = $urandom_range(99);
    if (r < 35) send_item(tile_cmd(CMD_ADD, near_coord(), near_coord(), near_coord()));
    else if (r < 55) send_item(tile_cmd(CMD_REMOVE, near_coord(), near_coord(), near_coord()));
    else if (r < 75) send_item(tile_cmd(CMD_CONTAINS, near_coord(), near_coord(),
                                        near_coord()));
    else if (r < 80) send_item(tile_cmd(CMD_CLEAR, int'($urandom), int'($urandom),
                                        int'($urandom)));
    else if (r < 84) begin
      d = tile_cmd(CMD_ADD, int'($urandom), int'($urandom), int'($urandom));
      d[2:0] = 3'($urandom_range(5, 7));
      send_item(d);
    end else if (r < 97) begin
      a = box_coord(5 << 16);
      b = box_coord(5 << 16);
      send_item(box_cmd(a, box_coord(4 << 16), box_coord(3 << 16),
                        a + $urandom_range(6 << 16), b, box_coord(3 << 16) + (2 << 16)));
    end else begin
      send_item(box_cmd($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        logic [9:0] e;
        e = expected_q.pop_front();
        n_checked++;
        if (m_axis_tdata[0] !== e[0])
          $display("%0t: found exp %b got %b", $time, e[0], m_axis_tdata[0]);
        if (m_axis_tdata[1] !== e[1])
          $display("%0t: accepted exp %b got %b", $time, e[1], m_axis_tdata[1]);
        if (m_axis_tdata[2] !== e[2])
          $display("%0t: overflow exp %b got %b", $time, e[2], m_axis_tdata[2]);
        if (m_axis_tdata[9:3] !== e[9:3])
          $display("%0t: entry_count exp %0d got %0d", $time, e[9:3], m_axis_tdata[9:3]);
        if (m_axis_tdata[9:0] !== e || m_axis_tdata[15:10] !== '0) errors++;
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !hold_recv && !(recv_idle > 0 && $urandom_range(99) < recv_idle);
  end

  task automatic test_directed();
    send_item(tile_cmd(CMD_CONTAINS, 0, 0, 0));
    send_item(tile_cmd(CMD_REMOVE, 0, 0, 0));
    send_item(tile_cmd(CMD_ADD, 'h8000, 'h7FFF, 'hFFFF));
    send_item(tile_cmd(CMD_ADD, 'h7FFF, 'h8000, 'h0000));
    send_item(tile_cmd(CMD_ADD, 'h8000, 'h7FFF, 'hFFFF));
    send_item(tile_cmd(CMD_CONTAINS, 'h8000, 'h7FFF, 'hFFFF));
    send_item(tile_cmd(CMD_CONTAINS, 'h8000, 'h7FFF, 'h0000));
    send_item(tile_cmd(CMD_REMOVE, 'h8000, 'h7FFF, 'hFFFF));
    send_item(tile_cmd(CMD_CONTAINS, 'h8000, 'h7FFF, 'hFFFF));
    send_item(tile_cmd(cmd_e'(3'd7), 1, 2, 3));
    send_item(tile_cmd(cmd_e'(3'd5), 1, 2, 3));
    send_item(tile_cmd(CMD_CLEAR, 0, 0, 0));
    send_item(box_cmd(-(2 << 16), -(2 << 16), -(2 << 16), 2 << 16, 2 << 16, 2 << 16));
    send_item(box_cmd(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(tile_cmd(CMD_ADD, 1, 1, 1));
    send_item(box_cmd(5 << 16, 0, 0, 1 << 16, 3 << 16, 2 << 16));
    send_item(box_cmd(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    for (int i = 0; i < 3; i++) send_item(tile_cmd(CMD_ADD, i, 0, 0));
  endtask

  task automatic test_full_list();
    send_item(tile_cmd(CMD_CLEAR, 0, 0, 0));
    for (int i = 0; i < Depth + 2; i++) send_item(tile_cmd(CMD_ADD, i, -i, 5));
    send_item(tile_cmd(CMD_REMOVE, 0, 0, 5));
    send_item(tile_cmd(CMD_REMOVE, Depth - 1, 1 - Depth, 5));
  endtask

  task automatic test_config_sweep();
    logic [31:0] vals [4];
    wait_drained();
    vals = '{32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'h0000_0001};
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_INV_X, p == 3 ? 32'hFFFF_FFFF : vals[p]);
      write_reg(REG_INV_Y, p == 2 ? 32'h0000_0000 : vals[(p + 1) % 4]);
      write_reg(REG_INV_Z, vals[(p + 2) % 4] | 32'h1);
      write_reg(REG_THR, p == 0 ? 32'h0 : p == 1 ? 32'hFFFF : 32'($urandom_range(65535)));
      for (int i = 0; i < 40; i++) random_item();
      wait_drained();
    end
    write_reg(REG_INV_X, 32'h0001_0000);
    write_reg(REG_INV_Y, 32'h0001_0000);
    write_reg(REG_INV_Z, 32'h0001_0000);
    write_reg(REG_THR, 32'h8000);
  endtask

  task automatic test_random_phases();
    int idle_pairs [3][2];
    idle_pairs = '{'{38, 65}, '{65, 38}, '{0, 0}};
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = idle_pairs[ph][0];
      recv_idle = idle_pairs[ph][1];
      for (int i = 0; i < 260; i++) random_item();
    end
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    hold_recv = 1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_recv = 0;
      end
      for (int i = 0; i < 12; i++) random_item();
    join
    wait_drained();
    for (int i = 0; i < 30; i++) random_item();
  endtask

  initial begin
    inv_x = 32'h0001_0000; inv_y = 32'h0001_0000; inv_z = 32'h0001_0000;
    thr = 16'h8000;
    fill = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_list();
    test_config_sweep();
    test_random_phases();
    test_backpressure();
    wait_drained();
    $display("Sent %0d commands, checked %0d results; %0d builds (%0d overflowed), %0d full adds.",
             n_sent, n_checked, n_builds, n_overflow, n_full);
    $display("Covered all registers with extreme settings, idle mixes and a long output stall.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_tile_occupancy_set passed");
    end else begin
      $display("tb_tile_occupancy_set failed");
    end
    $finish;
  end

endmodule

### tile_occupancy_set.f
src/tos_pkg.sv
src/tos_cell.sv
src/tos_scale.sv
src/tile_occupancy_set.sv
verif/tb_tile_occupancy_set.sv
